/* rtl/pls_pkg.sv */
package pls_pkg;

	// operation codes
	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_BACK  = 3'd1;
	localparam logic [2:0] OP_INS_AT    = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_BACK  = 3'd4;
	localparam logic [2:0] OP_DEL_AT    = 3'd5;
	localparam logic [2:0] OP_DISPLAY   = 3'd6;
	localparam logic [2:0] OP_COUNT     = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	// index width that covers the largest supported list (64 entries plus one)
	localparam int LIST_IDX_W = 7;

	// cell commands
	localparam logic [1:0] CM_HOLD = 2'd0;
	localparam logic [1:0] CM_INS  = 2'd1;
	localparam logic [1:0] CM_DEL  = 2'd2;
	localparam logic [1:0] CM_ROT  = 2'd3;

	typedef logic signed [31:0] elem_t;
	typedef logic [LIST_IDX_W-1:0] lidx_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic [1:0] mode;
		lidx_t      idx;
		elem_t      value;
	} cell_ctl_t;

endpackage

/* rtl/positional_list_store_unit.sv */
// positional list store: an ordered list of signed 32-bit values, at most
// CAPACITY of them, held in a chain of cells, one element per cell.
// input channel s_*: one item per operation (insert front/back/at position,
// delete front/back/at position, display, count). s_tready is high while
// no display is being streamed and the output register is free or draining.
// output channel m_*: status results carry the element count after the
// operation, element zero and tlast high. display of a non-empty list
// streams one result per element in list order, tlast on the final one;
// on an empty list it gives one list_empty result.
// a status result is loaded into the output register at the edge that
// accepts the operation; the first display element passes the display
// state first and then the output register. insert and delete shift
// every cell in parallel at the same edge. display rotates the cell
// chain, one element leaving the head per cycle while the output
// register may load; the tail takes it back, leaving the list intact.
// a stalled receiver (m_tready low) holds the output register and with it
// the rotation and the input side; nothing is dropped.
// reset clears the element count, the output valid and the display state;
// the cell contents are not cleared and are only read below the count.
module positional_list_store_unit #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // operation[2:0], value[34:3], position[40:35], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // element[31:0], count[37:32], zero fill
	output logic [1:0]  m_tuser,   // status[1:0]
	output logic        m_tlast
);
	import pls_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// input fields
	logic [2:0] in_op;
	elem_t      in_value;
	logic [5:0] in_pos;
	assign in_op    = s_tdata[2:0];
	assign in_value = s_tdata[34:3];
	assign in_pos   = s_tdata[40:35];

	// list state
	logic [CNT_W-1:0] count_q;
	logic             disp_q;     // display stream in progress
	logic [CNT_W-1:0] rem_q;      // elements still to stream

	// output register
	logic       m_tvalid_q;
	logic [1:0] status_q;
	elem_t      elem_q;
	logic [5:0] cnt_out_q;
	logic       last_q;

	logic      ld;          // output register may take a new result
	logic      in_acc;
	logic      rot_en;      // emit one display element this cycle
	logic      disp_start;
	logic      full;
	lidx_t     cnt_x;
	lidx_t     pos_x;
	lidx_t     cnt_nx;
	logic [1:0] st;
	cell_ctl_t ctl;

	elem_t cell_d [CAPACITY];

	assign ld       = !m_tvalid_q || m_tready;
	assign s_tready = !disp_q && ld;
	assign in_acc   = s_tvalid && s_tready;
	assign rot_en   = disp_q && ld;

	assign cnt_x = LIST_IDX_W'(count_q);
	assign pos_x = LIST_IDX_W'(in_pos);
	assign full  = (count_q == CNT_W'(CAPACITY));

	assign disp_start = in_acc && (in_op == OP_DISPLAY) && (cnt_x != '0);

	// decode the operation into a chain command, status and new count
	always_comb begin
		st        = ST_OK;
		cnt_nx    = cnt_x;
		ctl.mode  = CM_HOLD;
		ctl.idx   = '0;
		ctl.value = in_value;
		if (in_acc) begin
			case (in_op)
				OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
					if (full) begin
						st = ST_FULL;
					end else if (in_op == OP_INS_AT &&
					             (pos_x == '0 || pos_x > cnt_x + lidx_t'(1))) begin
						st = ST_BADPOS;
					end else begin
						ctl.mode = CM_INS;
						if (in_op == OP_INS_FRONT) begin
							ctl.idx = '0;
						end else if (in_op == OP_INS_BACK) begin
							ctl.idx = cnt_x;
						end else begin
							ctl.idx = pos_x - lidx_t'(1);
						end
						cnt_nx = cnt_x + lidx_t'(1);
					end
				end
				OP_DEL_FRONT, OP_DEL_BACK: begin
					if (cnt_x == '0) begin
						st = ST_EMPTY;
					end else begin
						ctl.mode = CM_DEL;
						ctl.idx  = (in_op == OP_DEL_FRONT) ? '0 : cnt_x - lidx_t'(1);
						cnt_nx   = cnt_x - lidx_t'(1);
					end
				end
				OP_DEL_AT: begin
					if (pos_x == '0 || pos_x > cnt_x) begin
						st = ST_BADPOS;
					end else begin
						ctl.mode = CM_DEL;
						ctl.idx  = pos_x - lidx_t'(1);
						cnt_nx   = cnt_x - lidx_t'(1);
					end
				end
				OP_DISPLAY: begin
					if (cnt_x == '0) begin
						st = ST_EMPTY;
					end
				end
				default: begin
					// count: status only
				end
			endcase
		end else if (rot_en) begin
			ctl.mode = CM_ROT;
			ctl.idx  = cnt_x - lidx_t'(1);
		end
	end

	// chain of cells, each talks to its neighbors only, plus the head tap
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		elem_t left_d;
		elem_t right_d;
		if (i == 0) begin : g_first
			assign left_d = cell_d[0];
		end else begin : g_mid_l
			assign left_d = cell_d[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_d[i];
		end else begin : g_mid_r
			assign right_d = cell_d[i+1];
		end
		pls_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.left_d (left_d),
			.right_d(right_d),
			.head_d (cell_d[0]),
			.d      (cell_d[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			disp_q     <= 1'b0;
			rem_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				count_q <= CNT_W'(cnt_nx);
			end
			if (disp_start) begin
				disp_q <= 1'b1;
				rem_q  <= count_q;
			end else if (rot_en) begin
				rem_q  <= rem_q - CNT_W'(1);
				disp_q <= (rem_q != CNT_W'(1));
			end
			if (ld) begin
				m_tvalid_q <= (in_acc && !disp_start) || rot_en;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ld) begin
			if (rot_en) begin
				status_q  <= ST_OK;
				elem_q    <= cell_d[0];
				cnt_out_q <= cnt_x[5:0];
				last_q    <= (rem_q == CNT_W'(1));
			end else begin
				status_q  <= st;
				elem_q    <= '0;
				cnt_out_q <= cnt_nx[5:0];
				last_q    <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, cnt_out_q, elem_q};
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

	// the list never outgrows the chain
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	// no new item while a display is streaming
	a_disp_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		disp_q |-> !s_tready)
		else $error("input taken during display");

	// a refused insert leaves the count alone
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && full && (in_op == OP_INS_FRONT || in_op == OP_INS_BACK ||
		 in_op == OP_INS_AT)) |=> $stable(count_q))
		else $error("count changed on refused insert");

	// the final display element ends the stream and is marked last
	a_disp_end: assert property (@(posedge clk) disable iff (!arst_n)
		(rot_en && rem_q == CNT_W'(1)) |=> (!disp_q && m_tvalid && m_tlast))
		else $error("display stream ended wrongly");

	// a display never emits while the list is empty
	a_disp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		disp_q |-> (count_q != '0 && rem_q != '0))
		else $error("display active on empty list");

endmodule

/* rtl/pls_cell.sv */
module pls_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  pls_pkg::cell_ctl_t ctl,
	input  pls_pkg::elem_t     left_d,
	input  pls_pkg::elem_t     right_d,
	input  pls_pkg::elem_t     head_d,
	output pls_pkg::elem_t     d
);
	import pls_pkg::*;

	localparam lidx_t MY_IDX = LIST_IDX_W'(IDX);

	elem_t d_q;

	always_ff @(posedge clk) begin
		case (ctl.mode)
			CM_INS: begin
				if (MY_IDX == ctl.idx) begin
					d_q <= ctl.value;
				end else if (MY_IDX > ctl.idx) begin
					d_q <= left_d;
				end
			end
			CM_DEL: begin
				if (MY_IDX >= ctl.idx) begin
					d_q <= right_d;
				end
			end
			CM_ROT: begin
				// rotate the occupied part, idx is the tail position
				if (MY_IDX < ctl.idx) begin
					d_q <= right_d;
				end else if (MY_IDX == ctl.idx) begin
					d_q <= head_d;
				end
			end
			default: begin
			end
		endcase
	end

	assign d = d_q;

endmodule
